@@ rtl/core/ille_pkg.sv @@
// shared types and constants of the indexed linked list engine
`default_nettype none

package ille_pkg;

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 9;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // status codes on the result channel
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified operation
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_HEAD,
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_NOP
    } op_kind_t;

    // one queued operation
    typedef struct packed {
        op_kind_t                  kind;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   value;
    } op_item_t;

endpackage

`default_nettype wire

@@ rtl/core/ille_front.sv @@
// front stage: takes input transfers, classifies the command and feeds the queue
`default_nettype none

module ille_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ille_pkg::CMD_W-1:0]        cmd,
    input  wire logic [ille_pkg::POS_W-1:0]        position,
    input  wire logic signed [ille_pkg::VAL_W-1:0] item_value,
    output logic                                   push_valid,
    output ille_pkg::op_item_t                     push_item,
    input  wire logic                              queue_full
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    ille_pkg::op_item_t hold_reg;
    ille_pkg::op_item_t hold_next;
    ille_pkg::op_kind_t kind;
    logic               accept;

    // command decode
    always_comb
    begin
        unique case (cmd)
            ille_pkg::CMD_APPEND: kind = ille_pkg::OP_APPEND;
            ille_pkg::CMD_HEAD:   kind = ille_pkg::OP_HEAD;
            ille_pkg::CMD_INSERT: kind = ille_pkg::OP_INSERT;
            ille_pkg::CMD_DELETE: kind = ille_pkg::OP_DELETE;
            ille_pkg::CMD_READ:   kind = ille_pkg::OP_READ;
            default:              kind = ille_pkg::OP_NOP;
        endcase
    end

    // holding register handshake
    assign in_stall   = hold_valid_reg && queue_full;
    assign accept     = in_valid && !in_stall;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (accept)
        begin
            hold_valid_next    = 1'b1;
            hold_next.kind     = kind;
            hold_next.position = position;
            hold_next.value    = item_value;
        end
        else if (hold_valid_reg && !queue_full)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ille_queue.sv @@
// short queue of classified operations between front and back
`default_nettype none

module ille_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    input  wire ille_pkg::op_item_t push_item,
    output logic                    full,
    output logic                    pop_valid,
    output ille_pkg::op_item_t      pop_item,
    input  wire logic               pop_ready
);

    localparam int DEPTH = ille_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ille_pkg::op_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ille_back.sv @@
// back stage: slot memories, list bookkeeping, link walk and result register
`default_nettype none

module ille_back #(
    parameter int CAPACITY = 256
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop_valid,
    input  wire ille_pkg::op_item_t                pop_item,
    output logic                                   pop_ready,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [ille_pkg::VAL_W-1:0]      read_value,
    output logic [ille_pkg::STAT_W-1:0]            status,
    output logic [ille_pkg::OCNT_W-1:0]            item_count
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = ille_pkg::POS_W;
    localparam int VAL_W  = ille_pkg::VAL_W;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_START,
        S_WALK,
        S_PRED_RD,
        S_PRED_W,
        S_ALLOC,
        S_ALLOC_W,
        S_COMMIT,
        S_LINK2,
        S_TGT_RD,
        S_TGT_W,
        S_FREE
    } state_t;

    typedef enum logic [2:0] {
        ACT_TAIL,
        ACT_HEAD,
        ACT_INS,
        ACT_DEL0,
        ACT_DEL,
        ACT_READ
    } act_t;

    // slot memories
    logic signed [VAL_W-1:0]  value_mem [CAPACITY];
    logic [SLOT_W-1:0]        link_mem [CAPACITY];
    logic signed [VAL_W-1:0]  value_rdata;
    logic [SLOT_W-1:0]        link_rdata;
    logic                     value_we;
    logic [SLOT_W-1:0]        value_waddr;
    logic signed [VAL_W-1:0]  value_wdata;
    logic                     link_we;
    logic [SLOT_W-1:0]        link_waddr;
    logic [SLOT_W-1:0]        link_wdata;
    logic [SLOT_W-1:0]        link_raddr;

    // control and bookkeeping registers
    state_t                   state_reg, state_next;
    act_t                     act_reg, act_next;
    logic [POS_W-1:0]         left_reg, left_next;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic signed [VAL_W-1:0]  rv_reg, rv_next;
    logic [SLOT_W-1:0]        head_reg, head_next;
    logic [SLOT_W-1:0]        tail_reg, tail_next;
    logic [SLOT_W-1:0]        free_head_reg, free_head_next;
    logic [SLOT_W-1:0]        cur_reg, cur_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [SLOT_W-1:0]        nlink_reg, nlink_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         free_count_reg, free_count_next;
    logic [CNT_W-1:0]         fresh_reg, fresh_next;

    // result register
    logic                              out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0]           out_value_reg, out_value_next;
    logic [ille_pkg::STAT_W-1:0]       out_status_reg, out_status_next;
    logic [ille_pkg::OCNT_W-1:0]       out_count_reg, out_count_next;

    // finish strobe for the current operation
    logic                              fin;
    logic signed [VAL_W-1:0]           fin_value;
    logic [ille_pkg::STAT_W-1:0]       fin_status;
    logic [CNT_W-1:0]                  fin_count;

    logic                     out_free;
    logic                     list_full;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         cnt_w;

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign status     = out_status_reg;
    assign item_count = out_count_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign list_full = (count_reg == CNT_W'(CAPACITY));
    assign pos_w     = CMP_W'(pop_item.position);
    assign cnt_w     = CMP_W'(count_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        left_next       = left_reg;
        val_next        = val_reg;
        rv_next         = rv_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        nlink_next      = nlink_reg;
        count_next      = count_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        pop_ready       = 1'b0;
        value_we        = 1'b0;
        value_waddr     = slot_reg;
        value_wdata     = val_reg;
        link_we         = 1'b0;
        link_waddr      = slot_reg;
        link_wdata      = free_head_reg;
        link_raddr      = cur_reg;
        fin             = 1'b0;
        fin_value       = '0;
        fin_status      = ille_pkg::ST_OK;
        fin_count       = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    pop_ready = 1'b1;
                    val_next  = pop_item.value;
                    cur_next  = head_reg;
                    slot_next = head_reg;
                    case (pop_item.kind)
                        ille_pkg::OP_APPEND,
                        ille_pkg::OP_HEAD:
                        begin
                            if (list_full)
                            begin
                                fin        = 1'b1;
                                fin_status = ille_pkg::ST_FULL;
                            end
                            else
                            begin
                                act_next   = (pop_item.kind == ille_pkg::OP_APPEND) ?
                                             ACT_TAIL : ACT_HEAD;
                                state_next = S_ALLOC;
                            end
                        end
                        ille_pkg::OP_INSERT:
                        begin
                            if (pos_w > cnt_w)
                            begin
                                fin        = 1'b1;
                                fin_status = ille_pkg::ST_RANGE;
                            end
                            else if (list_full)
                            begin
                                fin        = 1'b1;
                                fin_status = ille_pkg::ST_FULL;
                            end
                            else if (pop_item.position == '0)
                            begin
                                act_next   = ACT_HEAD;
                                state_next = S_ALLOC;
                            end
                            else if (pos_w == cnt_w)
                            begin
                                act_next   = ACT_TAIL;
                                state_next = S_ALLOC;
                            end
                            else
                            begin
                                // walk to the predecessor
                                act_next   = ACT_INS;
                                left_next  = pop_item.position - POS_W'(1);
                                state_next = (pop_item.position == POS_W'(1)) ?
                                             S_PRED_RD : S_WALK_START;
                            end
                        end
                        ille_pkg::OP_DELETE,
                        ille_pkg::OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ille_pkg::ST_EMPTY;
                            end
                            else if (pos_w >= cnt_w)
                            begin
                                fin        = 1'b1;
                                fin_status = ille_pkg::ST_RANGE;
                            end
                            else if (pop_item.kind == ille_pkg::OP_READ)
                            begin
                                act_next   = ACT_READ;
                                left_next  = pop_item.position;
                                state_next = (pop_item.position == '0) ?
                                             S_TGT_RD : S_WALK_START;
                            end
                            else if (pop_item.position == '0)
                            begin
                                act_next   = ACT_DEL0;
                                state_next = S_TGT_RD;
                            end
                            else
                            begin
                                act_next   = ACT_DEL;
                                left_next  = pop_item.position - POS_W'(1);
                                state_next = (pop_item.position == POS_W'(1)) ?
                                             S_PRED_RD : S_WALK_START;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_WALK_START:
            begin
                link_raddr = cur_reg;
                state_next = S_WALK;
            end

            // one link per cycle, read data feeds the next address
            S_WALK:
            begin
                if (left_reg == POS_W'(1))
                begin
                    cur_next   = link_rdata;
                    slot_next  = link_rdata;
                    state_next = (act_reg == ACT_READ) ? S_TGT_RD : S_PRED_RD;
                end
                else
                begin
                    link_raddr = link_rdata;
                    left_next  = left_reg - POS_W'(1);
                end
            end

            S_PRED_RD:
            begin
                link_raddr = cur_reg;
                state_next = S_PRED_W;
            end

            S_PRED_W:
            begin
                if (act_reg == ACT_INS)
                begin
                    nlink_next = link_rdata;
                    state_next = S_ALLOC;
                end
                else
                begin
                    slot_next  = link_rdata;
                    state_next = S_TGT_RD;
                end
            end

            // freed slots first, then the never-used ones
            S_ALLOC:
            begin
                if (free_count_reg != '0)
                begin
                    link_raddr = free_head_reg;
                    state_next = S_ALLOC_W;
                end
                else
                begin
                    slot_next  = fresh_reg[SLOT_W-1:0];
                    fresh_next = fresh_reg + CNT_W'(1);
                    state_next = S_COMMIT;
                end
            end

            S_ALLOC_W:
            begin
                slot_next       = free_head_reg;
                free_head_next  = link_rdata;
                free_count_next = free_count_reg - CNT_W'(1);
                state_next      = S_COMMIT;
            end

            S_COMMIT:
            begin
                value_we    = 1'b1;
                value_waddr = slot_reg;
                value_wdata = val_reg;
                case (act_reg)
                    ACT_TAIL:
                    begin
                        if (count_reg != '0)
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_reg;
                            link_wdata = slot_reg;
                        end
                        else
                        begin
                            head_next = slot_reg;
                        end
                        tail_next  = slot_reg;
                        count_next = count_reg + CNT_W'(1);
                        fin        = 1'b1;
                        fin_count  = count_reg + CNT_W'(1);
                    end
                    ACT_HEAD:
                    begin
                        if (count_reg != '0)
                        begin
                            link_we    = 1'b1;
                            link_waddr = slot_reg;
                            link_wdata = head_reg;
                        end
                        else
                        begin
                            tail_next = slot_reg;
                        end
                        head_next  = slot_reg;
                        count_next = count_reg + CNT_W'(1);
                        fin        = 1'b1;
                        fin_count  = count_reg + CNT_W'(1);
                    end
                    default:
                    begin
                        // mid-list insert: new slot takes the predecessor's link
                        link_we    = 1'b1;
                        link_waddr = slot_reg;
                        link_wdata = nlink_reg;
                        state_next = S_LINK2;
                    end
                endcase
            end

            S_LINK2:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
                count_next = count_reg + CNT_W'(1);
                fin        = 1'b1;
                fin_count  = count_reg + CNT_W'(1);
            end

            S_TGT_RD:
            begin
                link_raddr = slot_reg;
                state_next = S_TGT_W;
            end

            S_TGT_W:
            begin
                rv_next    = value_rdata;
                state_next = S_FREE;
                case (act_reg)
                    ACT_READ:
                    begin
                        fin       = 1'b1;
                        fin_value = value_rdata;
                    end
                    ACT_DEL0:
                    begin
                        head_next = link_rdata;
                    end
                    default:
                    begin
                        // unlink the target, tail moves back when it goes
                        if (slot_reg != tail_reg)
                        begin
                            link_we    = 1'b1;
                            link_waddr = cur_reg;
                            link_wdata = link_rdata;
                        end
                        else
                        begin
                            tail_next = cur_reg;
                        end
                    end
                endcase
            end

            S_FREE:
            begin
                link_we         = 1'b1;
                link_waddr      = slot_reg;
                link_wdata      = free_head_reg;
                free_head_next  = slot_reg;
                free_count_next = free_count_reg + CNT_W'(1);
                count_next      = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                fin       = 1'b1;
                fin_value = rv_reg;
                fin_count = count_reg - CNT_W'(1);
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
        end

        // result register load and drain
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (fin)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = fin_value;
            out_status_next = fin_status;
            out_count_next  = ille_pkg::OCNT_W'(fin_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_TAIL;
            left_reg       <= '0;
            val_reg        <= '0;
            rv_reg         <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_head_reg  <= '0;
            cur_reg        <= '0;
            slot_reg       <= '0;
            nlink_reg      <= '0;
            count_reg      <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ille_pkg::ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            left_reg       <= left_next;
            val_reg        <= val_next;
            rv_reg         <= rv_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_head_reg  <= free_head_next;
            cur_reg        <= cur_next;
            slot_reg       <= slot_next;
            nlink_reg      <= nlink_next;
            count_reg      <= count_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    // value memory, registered read
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        value_rdata <= value_mem[slot_reg];
    end

    // link memory, registered read
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/indexed_linked_list_engine.sv @@
// top level of the indexed linked list engine
`default_nettype none

// Keeps a singly linked list of signed 32-bit values in CAPACITY slots and
// returns one result (value, status, count) for every command. A front stage
// registers and classifies each command and hands it through a two-entry
// queue to the back stage, which owns the slot and link memories and works
// one command at a time. In the back stage append and insert at head
// allocate a slot and commit it, with an extra link memory read when a freed
// slot is reused; index commands walk the links from the head one slot per
// cycle through the link memory read port before they touch the target. A
// finished result sits in an output register while the next commands are
// already being taken in; while that register is stalled, the back stage
// takes no new command.
module indexed_linked_list_engine #(
    parameter int CAPACITY = 256
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ille_pkg::CMD_W-1:0]        cmd,
    input  wire logic [ille_pkg::POS_W-1:0]        position,
    input  wire logic signed [ille_pkg::VAL_W-1:0] item_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [ille_pkg::VAL_W-1:0]      read_value,
    output logic [ille_pkg::STAT_W-1:0]            status,
    output logic [ille_pkg::OCNT_W-1:0]            item_count
);

    logic               push_valid;
    ille_pkg::op_item_t push_item;
    logic               queue_full;
    logic               pop_valid;
    ille_pkg::op_item_t pop_item;
    logic               pop_ready;

    // command intake
    ille_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .position   (position),
        .item_value (item_value),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // decoupling queue
    ille_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // list execution
    ille_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count)
    );

endmodule

`default_nettype wire

@@ test/tb_indexed_linked_list_engine.sv @@
// testbench of the indexed linked list engine with its own list predictor
module tb_indexed_linked_list_engine;

    localparam int SLOTS = 256;

    typedef struct packed {
        logic signed [ille_pkg::VAL_W-1:0] value;
        logic [ille_pkg::STAT_W-1:0]       stat;
        logic [ille_pkg::OCNT_W-1:0]       count;
    } list_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [ille_pkg::CMD_W-1:0]        cmd;
    logic [ille_pkg::POS_W-1:0]        position;
    logic signed [ille_pkg::VAL_W-1:0] item_value;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [ille_pkg::VAL_W-1:0] read_value;
    logic [ille_pkg::STAT_W-1:0]       status;
    logic [ille_pkg::OCNT_W-1:0]       item_count;

    // predicted list state
    logic [ille_pkg::VAL_W-1:0] slot_val [SLOTS];
    logic [ille_pkg::POS_W-1:0] slot_link [SLOTS];
    logic [ille_pkg::POS_W-1:0] head_idx;
    logic [ille_pkg::POS_W-1:0] tail_idx;
    int unsigned                list_len;
    logic [ille_pkg::POS_W-1:0] free_top;
    int unsigned                free_len;
    int unsigned                fresh_idx;

    list_result_t expected_results [$];
    int unsigned  mismatches;
    int unsigned  seen_results;
    bit           busy_sides;

    indexed_linked_list_engine u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [ille_pkg::POS_W-1:0] grab_slot();
        logic [ille_pkg::POS_W-1:0] s;
        if (free_len > 0)
        begin
            s = free_top;
            free_top = slot_link[s];
            free_len--;
        end
        else
        begin
            s = ille_pkg::POS_W'(fresh_idx);
            fresh_idx++;
        end
        return s;
    endfunction

    function automatic void drop_slot(input logic [ille_pkg::POS_W-1:0] s);
        slot_link[s] = free_top;
        free_top = s;
        free_len++;
    endfunction

    function automatic logic [ille_pkg::POS_W-1:0] slot_at(input int unsigned idx);
        logic [ille_pkg::POS_W-1:0] s;
        s = head_idx;
        for (int unsigned i = 0; i < idx; i++)
            s = slot_link[s];
        return s;
    endfunction

    function automatic void link_tail(input logic [ille_pkg::VAL_W-1:0] v);
        logic [ille_pkg::POS_W-1:0] s;
        s = grab_slot();
        slot_val[s] = v;
        slot_link[s] = '0;
        if (list_len == 0)
            head_idx = s;
        else
            slot_link[tail_idx] = s;
        tail_idx = s;
        list_len++;
    endfunction

    function automatic void link_head(input logic [ille_pkg::VAL_W-1:0] v);
        logic [ille_pkg::POS_W-1:0] s;
        s = grab_slot();
        slot_val[s] = v;
        if (list_len == 0)
        begin
            slot_link[s] = '0;
            tail_idx = s;
        end
        else
            slot_link[s] = head_idx;
        head_idx = s;
        list_len++;
    endfunction

    // apply one command to the predicted list and return its result
    function automatic list_result_t apply_command(input logic [ille_pkg::CMD_W-1:0] c,
                                                   input logic [ille_pkg::POS_W-1:0] p,
                                                   input logic [ille_pkg::VAL_W-1:0] v);
        list_result_t               r;
        logic [ille_pkg::POS_W-1:0] pred;
        logic [ille_pkg::POS_W-1:0] s;
        r.value = '0;
        r.stat = ille_pkg::ST_OK;
        if (c == ille_pkg::CMD_APPEND || c == ille_pkg::CMD_HEAD)
        begin
            if (list_len >= SLOTS)
                r.stat = ille_pkg::ST_FULL;
            else if (c == ille_pkg::CMD_APPEND)
                link_tail(v);
            else
                link_head(v);
        end
        else if (c == ille_pkg::CMD_INSERT)
        begin
            if (p > list_len)
                r.stat = ille_pkg::ST_RANGE;
            else if (list_len >= SLOTS)
                r.stat = ille_pkg::ST_FULL;
            else if (p == 0)
                link_head(v);
            else if (p == list_len)
                link_tail(v);
            else
            begin
                pred = slot_at(p - 1);
                s = grab_slot();
                slot_val[s] = v;
                slot_link[s] = slot_link[pred];
                slot_link[pred] = s;
                list_len++;
            end
        end
        else if (c == ille_pkg::CMD_DELETE || c == ille_pkg::CMD_READ)
        begin
            if (list_len == 0)
                r.stat = ille_pkg::ST_EMPTY;
            else if (p >= list_len)
                r.stat = ille_pkg::ST_RANGE;
            else if (c == ille_pkg::CMD_READ)
                r.value = slot_val[slot_at(p)];
            else if (p == 0)
            begin
                s = head_idx;
                r.value = slot_val[s];
                head_idx = slot_link[s];
                drop_slot(s);
                list_len--;
            end
            else
            begin
                pred = slot_at(p - 1);
                s = slot_link[pred];
                r.value = slot_val[s];
                slot_link[pred] = slot_link[s];
                if (s == tail_idx)
                    tail_idx = pred;
                drop_slot(s);
                list_len--;
            end
            if (list_len == 0)
            begin
                head_idx = '0;
                tail_idx = '0;
            end
        end
        r.count = ille_pkg::OCNT_W'(list_len);
        return r;
    endfunction

    // send one command and wait for its transfer, then maybe pause
    task automatic send_command(input logic [ille_pkg::CMD_W-1:0] c,
                                input logic [ille_pkg::POS_W-1:0] p,
                                input logic [ille_pkg::VAL_W-1:0] v);
        in_valid <= 1'b1;
        cmd <= c;
        position <= p;
        item_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_command(c, p, v));
        if (busy_sides && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // result stall bursts
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (busy_sides && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen_results++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value %0d status %0d count %0d",
                             read_value, status, item_count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_value !== want.value || status !== want.stat
                    || item_count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected value %0d status %0d count %0d, ",
                                 seen_results, want.value, want.stat, want.count,
                                 "got value %0d status %0d count %0d",
                                 read_value, status, item_count);
                end
            end
        end
    end

    // empty list, head and tail cases, unknown commands
    task automatic test_directed();
        send_command(ille_pkg::CMD_READ, 8'd0, 32'd0);
        send_command(ille_pkg::CMD_DELETE, 8'd0, 32'd0);
        send_command(ille_pkg::CMD_INSERT, 8'd1, 32'd5);
        send_command(ille_pkg::CMD_HEAD, 8'd0, 32'h7FFF_FFFF);
        send_command(ille_pkg::CMD_DELETE, 8'd0, 32'd0);
        send_command(ille_pkg::CMD_INSERT, 8'd0, 32'h8000_0000);
        send_command(ille_pkg::CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
        send_command(ille_pkg::CMD_INSERT, 8'd2, 32'd0);
        send_command(ille_pkg::CMD_INSERT, 8'd1, 32'h1234_5678);
        send_command(ille_pkg::CMD_INSERT, 8'd5, 32'd9);
        send_command(ille_pkg::CMD_READ, 8'd0, 32'd0);
        send_command(ille_pkg::CMD_READ, 8'd3, 32'd0);
        send_command(ille_pkg::CMD_READ, 8'd4, 32'd0);
        send_command(ille_pkg::CMD_READ, 8'd255, 32'd0);
        send_command(ille_pkg::CMD_DELETE, 8'd3, 32'd0);
        send_command(ille_pkg::CMD_APPEND, 8'd0, 32'd77);
        send_command(ille_pkg::CMD_DELETE, 8'd1, 32'd0);
        send_command(ille_pkg::CMD_DELETE, 8'd4, 32'd0);
        for (int k = 1; k <= 3; k++)
            send_command(ille_pkg::CMD_W'(ille_pkg::CMD_READ + k), 8'hFF, 32'hFFFF_FFFF);
        while (list_len > 0)
            send_command(ille_pkg::CMD_DELETE, ille_pkg::POS_W'(list_len - 1), 32'd0);
    endtask

    // fill to capacity, hit the full cases, empty again
    task automatic test_full_list();
        while (list_len < SLOTS)
            send_command($urandom_range(0, 1) ? ille_pkg::CMD_APPEND : ille_pkg::CMD_HEAD,
                         8'd0, $urandom);
        send_command(ille_pkg::CMD_APPEND, 8'd0, $urandom);
        send_command(ille_pkg::CMD_HEAD, 8'd0, $urandom);
        send_command(ille_pkg::CMD_INSERT, 8'd100, $urandom);
        send_command(ille_pkg::CMD_READ, 8'd255, 32'd0);
        send_command(ille_pkg::CMD_DELETE, 8'd255, 32'd0);
        send_command(ille_pkg::CMD_INSERT, 8'd255, $urandom);
        while (list_len > 0)
            send_command(ille_pkg::CMD_DELETE,
                         ille_pkg::POS_W'($urandom_range(0, list_len - 1)), 32'd0);
    endtask

    // random command mix, kept mostly on small lists
    task automatic test_random(input int n);
        logic [ille_pkg::CMD_W-1:0] c;
        logic [ille_pkg::POS_W-1:0] p;
        int unsigned                roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                c = ille_pkg::CMD_APPEND;
            else if (roll < 32)
                c = ille_pkg::CMD_HEAD;
            else if (roll < 55)
                c = ille_pkg::CMD_INSERT;
            else if (roll < 78)
                c = (list_len > 40) ? ille_pkg::CMD_DELETE : ille_pkg::CMD_READ;
            else if (roll < 97)
                c = ille_pkg::CMD_DELETE;
            else
                c = ille_pkg::CMD_W'($urandom_range(ille_pkg::CMD_READ + 1, 7));
            if ($urandom_range(0, 9) == 0)
                p = ille_pkg::POS_W'($urandom);
            else
                p = ille_pkg::POS_W'($urandom_range(0, list_len));
            send_command(c, p, $urandom);
        end
    endtask

    // stimulus
    initial
    begin
        in_valid = 1'b0;
        cmd = '0;
        position = '0;
        item_value = '0;
        rst_n = 1'b0;
        mismatches = 0;
        seen_results = 0;
        busy_sides = 1'b1;
        head_idx = '0;
        tail_idx = '0;
        list_len = 0;
        free_top = '0;
        free_len = 0;
        fresh_idx = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_random(1100);
        busy_sides = 1'b0;
        test_random(400);
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
